// ===== rtl/vahf_pkg.sv =====
// ----------------------------------------------------------------------------
// vahf_pkg
// Shared widths, state codes, register indexes and the result word layout
// of the voice activity hangover segmenter.
// ----------------------------------------------------------------------------
package vahf_pkg;

	localparam int RUN_WIDTH   = 16;
	localparam int COUNT_WIDTH = 32;
	localparam int CFG_WIDTH   = 16;
	localparam int POS_WIDTH   = COUNT_WIDTH + 1;
	localparam int STATE_WIDTH = 3;
	localparam int IDX_WIDTH   = 3;
	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 1;

	// segmenter state codes
	localparam logic [STATE_WIDTH-1:0] ST_SILENCE  = 3'd0;
	localparam logic [STATE_WIDTH-1:0] ST_START    = 3'd1;
	localparam logic [STATE_WIDTH-1:0] ST_CONTINUE = 3'd2;
	localparam logic [STATE_WIDTH-1:0] ST_PAUSE    = 3'd3;
	localparam logic [STATE_WIDTH-1:0] ST_END      = 3'd4;

	// configuration register indexes
	localparam logic [IDX_WIDTH-1:0] REG_START_RUN  = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_END_RUN    = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_PAUSE_RUN  = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_RESUME_RUN = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_MIN_SEG    = 3'd4;
	localparam logic [IDX_WIDTH-1:0] REG_MAX_PAUSE  = 3'd5;

	// configuration reset values
	localparam logic [CFG_WIDTH-1:0] START_RUN_RST  = 16'd3;
	localparam logic [CFG_WIDTH-1:0] END_RUN_RST    = 16'd10;
	localparam logic [CFG_WIDTH-1:0] PAUSE_RUN_RST  = 16'd5;
	localparam logic [CFG_WIDTH-1:0] RESUME_RUN_RST = 16'd2;
	localparam logic [CFG_WIDTH-1:0] MIN_SEG_RST    = 16'd13;
	localparam logic [CFG_WIDTH-1:0] MAX_PAUSE_RST  = 16'd63;

	// result word, last member in the lowest bits
	typedef struct packed {
		logic signed [POS_WIDTH-1:0] last_voiced;
		logic signed [POS_WIDTH-1:0] segment_start;
		logic [COUNT_WIDTH-1:0]      state_frames;
		logic [COUNT_WIDTH-1:0]      frame_index;
		logic [STATE_WIDTH-1:0]      prior_state;
		logic                        changed;
		logic [STATE_WIDTH-1:0]      seg_state;
	} res_t;

	localparam int RES_WIDTH   = $bits(res_t);
	localparam int OUT_TDATA_W = ((RES_WIDTH + 7) / 8) * 8;

endpackage

// ===== rtl/voice_activity_hangover_fsm_core.sv =====
// ----------------------------------------------------------------------------
// voice_activity_hangover_fsm_core
// Five-state speech segmenter driven by per-frame voice decisions.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per frame: s_tdata[0] is the voice flag, s_tuser[0]
//   the kind (0 frame decision, 1 clear all tracking). A clear returns every
//   counter, position and state to reset values but keeps the registers.
//   m_* returns one result word per input word, fields from bit 0 up:
//   seg_state, changed, prior_state, frame_index, state_frames, segment_start,
//   last_voiced, zero padded to 144 bits.
//   cfg_we/cfg_index/cfg_wdata write the six frame thresholds; write only
//   while no result is outstanding. Unknown indexes are dropped.
// Timing:
//   The segmenter state is updated in the cycle a word is accepted and the
//   result lands in the output register (or the skid register behind it), so
//   one word is taken every cycle while s_tready is high. The skid register
//   absorbs one extra result when m_tready drops; s_tready falls only when
//   both hold a result. Reset clears all tracking, loads the default
//   thresholds and empties the output side.
// ----------------------------------------------------------------------------
module voice_activity_hangover_fsm_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [vahf_pkg::IN_TDATA_W-1:0]      s_tdata,   // voice_flag, pad
	input  logic [vahf_pkg::IN_TUSER_W-1:0]      s_tuser,   // kind
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// seg_state, changed, prior_state, frame_index, state_frames,
	// segment_start, last_voiced, pad
	output logic [vahf_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                 cfg_we,
	input  logic [vahf_pkg::IDX_WIDTH-1:0]       cfg_index,
	input  logic [vahf_pkg::CFG_WIDTH-1:0]       cfg_wdata
);
	import vahf_pkg::*;

	localparam logic [RUN_WIDTH-1:0]   RUN_MAX   = '1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [POS_WIDTH-1:0]   POS_NONE  = '1;

	logic [CFG_WIDTH-1:0] start_run_q, end_run_q, pause_run_q;
	logic [CFG_WIDTH-1:0] resume_run_q, min_seg_q, max_pause_q;

	logic [STATE_WIDTH-1:0]      cur_state_q, prev_state_q;
	logic [RUN_WIDTH-1:0]        speech_run_q, silence_run_q;
	logic [COUNT_WIDTH-1:0]      frame_total_q, in_state_q;
	logic signed [POS_WIDTH-1:0] start_pos_q, voiced_pos_q;

	logic [STATE_WIDTH-1:0]      cur_state_d, prev_state_d, next_state;
	logic [RUN_WIDTH-1:0]        speech_run_d, silence_run_d;
	logic [COUNT_WIDTH-1:0]      frame_total_d, in_state_d, in_state_inc;
	logic signed [POS_WIDTH-1:0] start_pos_d, voiced_pos_d;
	logic                        changed_d, mark_start;

	res_t out_q, skid_q, res_d;
	logic out_valid_q, skid_valid_q;
	logic in_fire, out_fire, voice, clear;

	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - RES_WIDTH){1'b0}}, out_q};
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = out_valid_q && m_tready;
	assign clear    = s_tuser[0];
	assign voice    = s_tdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_run_q  <= START_RUN_RST;
			end_run_q    <= END_RUN_RST;
			pause_run_q  <= PAUSE_RUN_RST;
			resume_run_q <= RESUME_RUN_RST;
			min_seg_q    <= MIN_SEG_RST;
			max_pause_q  <= MAX_PAUSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_RUN:  start_run_q  <= cfg_wdata;
				REG_END_RUN:    end_run_q    <= cfg_wdata;
				REG_PAUSE_RUN:  pause_run_q  <= cfg_wdata;
				REG_RESUME_RUN: resume_run_q <= cfg_wdata;
				REG_MIN_SEG:    min_seg_q    <= cfg_wdata;
				REG_MAX_PAUSE:  max_pause_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame step: counters first, then the state decision on the new counts
	always_comb begin
		frame_total_d = (frame_total_q == COUNT_MAX) ? COUNT_MAX : frame_total_q + 1'b1;
		in_state_inc  = (in_state_q == COUNT_MAX) ? COUNT_MAX : in_state_q + 1'b1;
		if (voice) begin
			speech_run_d  = (speech_run_q == RUN_MAX) ? RUN_MAX : speech_run_q + 1'b1;
			silence_run_d = '0;
			voiced_pos_d  = {1'b0, frame_total_d};
		end else begin
			silence_run_d = (silence_run_q == RUN_MAX) ? RUN_MAX : silence_run_q + 1'b1;
			speech_run_d  = '0;
			voiced_pos_d  = voiced_pos_q;
		end

		next_state = cur_state_q;
		mark_start = 1'b0;
		unique case (cur_state_q)
			ST_START: begin
				if (voice)
					next_state = ST_CONTINUE;
				else if (silence_run_d >= end_run_q)
					next_state = (in_state_inc < {{(COUNT_WIDTH - CFG_WIDTH){1'b0}}, min_seg_q})
					             ? ST_SILENCE : ST_END;
			end
			ST_CONTINUE: begin
				if (silence_run_d >= pause_run_q)
					next_state = ST_PAUSE;
			end
			ST_PAUSE: begin
				if (speech_run_d >= resume_run_q)
					next_state = ST_CONTINUE;
				else if (silence_run_d >= max_pause_q)
					next_state = ST_END;
			end
			ST_END: begin
				if (speech_run_d >= start_run_q) begin
					next_state = ST_START;
					mark_start = 1'b1;
				end else begin
					next_state = ST_SILENCE;
				end
			end
			default: begin
				if (speech_run_d >= start_run_q) begin
					next_state = ST_START;
					mark_start = 1'b1;
				end
			end
		endcase

		changed_d = (next_state != cur_state_q);
		cur_state_d  = next_state;
		prev_state_d = changed_d ? cur_state_q : prev_state_q;
		in_state_d   = changed_d ? '0 : in_state_inc;
		start_pos_d  = mark_start
		               ? {1'b0, frame_total_d} - {{(POS_WIDTH - RUN_WIDTH){1'b0}}, speech_run_d}
		                 + {{(POS_WIDTH - 1){1'b0}}, 1'b1}
		               : start_pos_q;

		// clear overrides everything
		if (clear) begin
			cur_state_d   = ST_SILENCE;
			prev_state_d  = ST_SILENCE;
			speech_run_d  = '0;
			silence_run_d = '0;
			frame_total_d = '0;
			in_state_d    = '0;
			start_pos_d   = POS_NONE;
			voiced_pos_d  = POS_NONE;
			changed_d     = 1'b0;
		end

		res_d.seg_state     = cur_state_d;
		res_d.changed       = changed_d;
		res_d.prior_state   = prev_state_d;
		res_d.frame_index   = frame_total_d;
		res_d.state_frames  = in_state_d;
		res_d.segment_start = start_pos_d;
		res_d.last_voiced   = voiced_pos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_state_q   <= ST_SILENCE;
			prev_state_q  <= ST_SILENCE;
			speech_run_q  <= '0;
			silence_run_q <= '0;
			frame_total_q <= '0;
			in_state_q    <= '0;
			start_pos_q   <= POS_NONE;
			voiced_pos_q  <= POS_NONE;
		end else if (in_fire) begin
			cur_state_q   <= cur_state_d;
			prev_state_q  <= prev_state_d;
			speech_run_q  <= speech_run_d;
			silence_run_q <= silence_run_d;
			frame_total_q <= frame_total_d;
			in_state_q    <= in_state_d;
			start_pos_q   <= start_pos_d;
			voiced_pos_q  <= voiced_pos_d;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_fire)
					skid_valid_q <= 1'b0;
			end else if (in_fire && out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end
			if (out_fire && !skid_valid_q && !in_fire)
				out_valid_q <= 1'b0;
			else if (in_fire)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire)
				out_q <= skid_q;
		end else if (in_fire) begin
			if (!out_valid_q || out_fire)
				out_q <= res_d;
			else
				skid_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_runs_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(speech_run_q != '0 && silence_run_q != '0))
		else $error("speech and silence runs both nonzero");

	a_frame_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !clear && frame_total_q != COUNT_MAX)
		|=> frame_total_q == $past(frame_total_q) + 1'b1)
		else $error("frame count did not advance on a frame word");

	a_change_resets_dwell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.changed) |-> out_q.state_frames == '0)
		else $error("state change reported with nonzero dwell count");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && clear) |=> (cur_state_q == ST_SILENCE && frame_total_q == '0
		                        && start_pos_q == POS_NONE))
		else $error("clear did not restore tracking");
`endif

endmodule

// ===== tb/vahf_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// vahf_tb_pkg
// Input word kind codes shared by the segmenter testbench and its checker.
// ----------------------------------------------------------------------------
package vahf_tb_pkg;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

endpackage

// ===== tb/vahf_checker.sv =====
// ----------------------------------------------------------------------------
// vahf_checker
// Watches the input, output and register write channels of the hangover
// segmenter, predicts one result word per accepted input word and compares
// every returned word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module vahf_checker
	import vahf_pkg::*;
	import vahf_tb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [IDX_WIDTH-1:0]   cfg_index,
	input  logic [CFG_WIDTH-1:0]   cfg_wdata,
	output int                     mismatch_count,
	output int                     pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CFG_WIDTH-1:0]   start_run, stop_run, pause_run, resume_run, min_seg, max_pause;
	logic [STATE_WIDTH-1:0] seg_cur, seg_prev;
	logic [RUN_WIDTH-1:0]   speech_run, silence_run;
	logic [COUNT_WIDTH-1:0] frame_cnt, state_cnt;
	logic [POS_WIDTH-1:0]   start_pos, voiced_pos;
	res_t                   segment_reports[$];
	res_t                   want, got;

	function automatic void clear_tracking();
		seg_cur     = ST_SILENCE;
		seg_prev    = ST_SILENCE;
		speech_run  = '0;
		silence_run = '0;
		frame_cnt   = '0;
		state_cnt   = '0;
		start_pos   = '1;
		voiced_pos  = '1;
	endfunction

	function automatic res_t segment_step(input logic clear, input logic voice);
		res_t                   r;
		logic                   moved;
		logic [STATE_WIDTH-1:0] nxt;
		moved = 1'b0;
		if (clear) begin
			clear_tracking();
		end else begin
			if (frame_cnt != '1)
				frame_cnt = frame_cnt + 1'b1;
			if (state_cnt != '1)
				state_cnt = state_cnt + 1'b1;
			if (voice) begin
				if (speech_run != '1)
					speech_run = speech_run + 1'b1;
				silence_run = '0;
				voiced_pos  = {1'b0, frame_cnt};
			end else begin
				if (silence_run != '1)
					silence_run = silence_run + 1'b1;
				speech_run = '0;
			end
			nxt = seg_cur;
			case (seg_cur)
				ST_START: begin
					if (voice)
						nxt = ST_CONTINUE;
					else if (silence_run >= stop_run)
						nxt = (state_cnt < min_seg) ? ST_SILENCE : ST_END;
				end
				ST_CONTINUE: begin
					if (silence_run >= pause_run)
						nxt = ST_PAUSE;
				end
				ST_PAUSE: begin
					if (speech_run >= resume_run)
						nxt = ST_CONTINUE;
					else if (silence_run >= max_pause)
						nxt = ST_END;
				end
				ST_END: begin
					nxt = ST_SILENCE;
					if (speech_run >= start_run)
						nxt = ST_START;
				end
				default: begin
					if (speech_run >= start_run)
						nxt = ST_START;
				end
			endcase
			// segment begins where the current speech run began
			if (nxt == ST_START && seg_cur != ST_START)
				start_pos = {1'b0, frame_cnt} - {{(POS_WIDTH-RUN_WIDTH){1'b0}}, speech_run} + 1'b1;
			if (nxt != seg_cur) begin
				seg_prev  = seg_cur;
				seg_cur   = nxt;
				state_cnt = '0;
				moved     = 1'b1;
			end
		end
		r.seg_state     = seg_cur;
		r.changed       = moved;
		r.prior_state   = seg_prev;
		r.frame_index   = frame_cnt;
		r.state_frames  = state_cnt;
		r.segment_start = start_pos;
		r.last_voiced   = voiced_pos;
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [POS_WIDTH-1:0] exp_v,
			input logic [POS_WIDTH-1:0] act_v);
		if (exp_v !== act_v) begin
			if (mismatch_count < 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, field, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_run  = START_RUN_RST;
			stop_run   = END_RUN_RST;
			pause_run  = PAUSE_RUN_RST;
			resume_run = RESUME_RUN_RST;
			min_seg    = MIN_SEG_RST;
			max_pause  = MAX_PAUSE_RST;
			clear_tracking();
			segment_reports.delete();
			mismatch_count = 0;
			pending_count  = 0;
		end else begin
			// retire the output word first: it belongs to an earlier input word
			if (m_tvalid && m_tready) begin
				got = m_tdata[RES_WIDTH-1:0];
				if (segment_reports.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result word with none pending: %h", $realtime, got);
					mismatch_count++;
				end else begin
					want = segment_reports.pop_front();
					compare_field("seg_state", want.seg_state, got.seg_state);
					compare_field("changed", want.changed, got.changed);
					compare_field("prior_state", want.prior_state, got.prior_state);
					compare_field("frame_index", want.frame_index, got.frame_index);
					compare_field("state_frames", want.state_frames, got.state_frames);
					compare_field("segment_start", want.segment_start, got.segment_start);
					compare_field("last_voiced", want.last_voiced, got.last_voiced);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_START_RUN:  start_run  = cfg_wdata;
					REG_END_RUN:    stop_run   = cfg_wdata;
					REG_PAUSE_RUN:  pause_run  = cfg_wdata;
					REG_RESUME_RUN: resume_run = cfg_wdata;
					REG_MIN_SEG:    min_seg    = cfg_wdata;
					REG_MAX_PAUSE:  max_pause  = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				segment_reports.push_back(segment_step(s_tuser[0] == KIND_CLEAR, s_tdata[0]));
			pending_count = segment_reports.size();
		end
	end

endmodule

// ===== tb/tb_voice_activity_hangover_fsm_core.sv =====
// ----------------------------------------------------------------------------
// tb_voice_activity_hangover_fsm_core
// Drives frame decisions and clears into the hangover segmenter under
// several threshold settings and idling patterns, including a long output
// stall and a pass at the largest thresholds; the checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_voice_activity_hangover_fsm_core;
	timeunit 1ns;
	timeprecision 1ps;

	import vahf_pkg::*;
	import vahf_tb_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int LONG_RUN        = 20;

	localparam logic [IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;
	localparam logic SPEECH = 1'b1;
	localparam logic SILENT = 1'b0;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [IN_TUSER_W-1:0]  s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [IDX_WIDTH-1:0]   cfg_index = '0;
	logic [CFG_WIDTH-1:0]   cfg_wdata = '0;

	int   mismatch_count;
	int   pending_count;
	int   send_gap_pct  = 0;
	int   recv_gap_pct  = 0;
	logic hold_off_req  = 1'b0;
	int   hold_left     = 0;
	int   quiet_cycles  = 0;

	always #5 clk = ~clk;

	voice_activity_hangover_fsm_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	vahf_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// receiver: random back-pressure, or a counted hold-off when asked
	always @(negedge clk) begin
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			hold_left    = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input logic kind, input logic voice);
		logic [IN_TDATA_W-1:0] word;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		// pad bits carry noise, only bit 0 matters
		word     = IN_TDATA_W'($urandom);
		word[0]  = voice;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// hold the sender until every word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_thresholds(input int start_r, input int stop_r, input int pause_r,
			input int resume_r, input int min_s, input int max_p);
		drain();
		write_reg(REG_START_RUN, CFG_WIDTH'(start_r));
		write_reg(REG_END_RUN, CFG_WIDTH'(stop_r));
		write_reg(REG_PAUSE_RUN, CFG_WIDTH'(pause_r));
		write_reg(REG_RESUME_RUN, CFG_WIDTH'(resume_r));
		write_reg(REG_MIN_SEG, CFG_WIDTH'(min_s));
		write_reg(REG_MAX_PAUSE, CFG_WIDTH'(max_p));
	endtask

	task automatic random_thresholds();
		load_thresholds($urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(1, 8),
			$urandom_range(1, 4), $urandom_range(0, 16), $urandom_range(0, 24));
	endtask

	// runs of equal decisions reach the deeper states; some runs are noise
	task automatic send_runs(input int count);
		int   sent;
		int   len;
		logic voice;
		logic noisy;
		sent = 0;
		while (sent < count) begin
			voice = 1'($urandom_range(1));
			noisy = ($urandom_range(9) == 0);
			len   = $urandom_range(1, 24);
			repeat (len) begin
				if ($urandom_range(99) == 0)
					send_word(KIND_CLEAR, 1'($urandom_range(1)));
				else
					send_word(KIND_FRAME, noisy ? 1'($urandom_range(1)) : voice);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// spare indexes must not disturb the thresholds
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '0);

		// reset thresholds: start, continue, pause, resume, then clear
		repeat (4) send_word(KIND_FRAME, SPEECH);
		repeat (5) send_word(KIND_FRAME, SILENT);
		repeat (2) send_word(KIND_FRAME, SPEECH);
		send_word(KIND_CLEAR, SPEECH);

		// tight thresholds: fresh segment ends, restart, pause times out, back to silence
		load_thresholds(1, 2, 1, 1, 0, 1);
		send_word(KIND_FRAME, SPEECH);
		repeat (2) send_word(KIND_FRAME, SILENT);
		repeat (2) send_word(KIND_FRAME, SPEECH);
		repeat (3) send_word(KIND_FRAME, SILENT);

		// fresh segment shorter than the minimum drops back to silence
		load_thresholds(1, 2, 1, 1, 16'hFFFF, 1);
		send_word(KIND_FRAME, SPEECH);
		repeat (2) send_word(KIND_FRAME, SILENT);

		// zero start run: a silent frame opens a segment
		load_thresholds(0, 2, 1, 1, 0, 0);
		send_word(KIND_FRAME, SILENT);
		send_word(KIND_CLEAR, SILENT);

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			case (phase)
				0: begin
					send_gap_pct = 37;
					recv_gap_pct = 86;
				end
				1: begin
					send_gap_pct = 86;
					recv_gap_pct = 37;
				end
				default: begin
					send_gap_pct = 0;
					recv_gap_pct = 0;
				end
			endcase
			random_thresholds();
			send_runs(130);
			load_thresholds(1, 1, 1, 1, 0, 0);
			send_runs(130);
			random_thresholds();
			send_runs(130);
		end

		// long output stall while words keep coming: the block must fill and stall
		load_thresholds(START_RUN_RST, END_RUN_RST, PAUSE_RUN_RST, RESUME_RUN_RST,
			MIN_SEG_RST, MAX_PAUSE_RST);
		hold_off_req = 1'b1;
		send_runs(40);

		// largest thresholds: short runs never reach them
		load_thresholds('1, '1, '1, '1, '1, '1);
		send_word(KIND_CLEAR, SILENT);
		repeat (LONG_RUN) send_word(KIND_FRAME, SPEECH);
		repeat (LONG_RUN) send_word(KIND_FRAME, SILENT);

		drain();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
